FILE: src/rlfg_pkg.sv
// ----------------------------------------------------------------------------
// rlfg_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the rainbow LED frame generator.
// ----------------------------------------------------------------------------
package rlfg_pkg;

   localparam int LED_CAPACITY_DEFAULT = 64;

   // hue circle and level constants
   localparam int FULL_CIRCLE = 360;
   localparam int SECTOR_SPAN = 60;
   localparam int LEVEL_MAX   = 255;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_ADDR_W-1:0] REG_LED_COUNT  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SATURATION = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BRIGHTNESS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_HUE_STEP   = 3'd3;

   // register reset values
   localparam logic [6:0] LED_COUNT_RESET  = 7'd50;
   localparam logic [7:0] SATURATION_RESET = 8'd255;
   localparam logic [7:0] BRIGHTNESS_RESET = 8'd100;
   localparam logic [8:0] HUE_STEP_RESET   = 9'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // latch frame parameters, clear divider and accumulators
      logic div_step;    // one restoring division step of 360 / count
      logic calc_hue;    // hue of the current led, span = max - min
      logic calc_mul;    // sector, offset in sector, span * offset
      logic calc_rec;    // reciprocal multiply for the divide by 60
      logic calc_out;    // correct quotient, select channels into output regs
      logic advance;     // step to the next led
      logic frame_done;  // advance the base hue
   } rlfg_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;    // current division step is the final one
      logic last;        // led in the output register closes the frame
   } rlfg_sts_type;

endpackage

FILE: src/rainbow_led_frame_generator.sv
// ----------------------------------------------------------------------------
// rainbow_led_frame_generator
// Per frame request, emits one rgb color per led of a rainbow spread over the
// strip, then rotates the rainbow by the configured hue step.
//
//   channel | dir | transfer                 | payload
//   req_    | in  | one frame request        | tdata[0] frame_tick
//   rsp_    | out | one led color            | tdata led_index/red/green/blue, tlast
//   csr_    | in  | register write, no wait  | addr = register index, wdata
//
// With rsp_tready held high, a frame runs the bit-serial divider for the hue
//   spacing, then steps each led through the stepped hue, multiply, reciprocal
//   and select stages plus the output state.
// A tick of zero is taken and emits nothing.
// Reset is synchronous; it restores the register defaults and a base hue of 0.
// A stalled result holds the datapath; req_tready is high only between frames.
// ----------------------------------------------------------------------------
module rainbow_led_frame_generator #(
   parameter int LED_CAPACITY = rlfg_pkg::LED_CAPACITY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [0] frame_tick, [7:1] zero
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [5:0] led_index, [13:6] red,
                                                        // [21:14] green, [29:22] blue,
                                                        // [31:30] zero
   output logic                            rsp_tlast,   // frame_last
   // configuration port
   input  logic                            csr_we,
   input  logic [rlfg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rlfg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rlfg_pkg::rlfg_cmd_type cmd;
   rlfg_pkg::rlfg_sts_type sts;

   logic [5:0] led_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   rlfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .frame_tick (req_tdata[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rlfg_datapath #(
      .LED_CAPACITY (LED_CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .led_index  (led_index),
      .red        (red),
      .green      (green),
      .blue       (blue),
      .frame_last (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, blue, green, red, led_index};

endmodule

FILE: src/rlfg_ctrl.sv
// ----------------------------------------------------------------------------
// rlfg_ctrl
// Frame sequencer: accepts frame requests, runs the per-frame setup and steps
// the datapath through each led, holding the result until it is taken.
// ----------------------------------------------------------------------------
module rlfg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  frame_tick,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rlfg_pkg::rlfg_sts_type sts,
   output rlfg_pkg::rlfg_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_HUE  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_REC  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && frame_tick) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_HUE;
            end
         end
         ST_HUE: begin
            cmd.calc_hue = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = ST_REC;
         end
         ST_REC: begin
            cmd.calc_rec = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            cmd.calc_out = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.last) begin
                  cmd.frame_done = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_HUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/rlfg_datapath.sv
// ----------------------------------------------------------------------------
// rlfg_datapath
// Configuration registers, hue spacing divider, hue accumulator and the
// integer hsv to rgb conversion with its output register.
// ----------------------------------------------------------------------------
module rlfg_datapath #(
   parameter int LED_CAPACITY = rlfg_pkg::LED_CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rlfg_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rlfg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  rlfg_pkg::rlfg_cmd_type            cmd,
   output rlfg_pkg::rlfg_sts_type            sts,
   output logic [5:0]                        led_index,
   output logic [7:0]                        red,
   output logic [7:0]                        green,
   output logic [7:0]                        blue,
   output logic                              frame_last
);

   localparam int CNT_W = $clog2(LED_CAPACITY + 1);
   localparam int RECIP15 = 4369;   // 65535 / 15
   localparam logic [9:0] CIRCLE10 = 10'(rlfg_pkg::FULL_CIRCLE);
   localparam logic [8:0] CIRCLE9  = 9'(rlfg_pkg::FULL_CIRCLE);

   // configuration registers
   logic [6:0] led_count_ff;
   logic [7:0] saturation_ff;
   logic [7:0] brightness_ff;
   logic [8:0] hue_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff  <= rlfg_pkg::LED_COUNT_RESET;
         saturation_ff <= rlfg_pkg::SATURATION_RESET;
         brightness_ff <= rlfg_pkg::BRIGHTNESS_RESET;
         hue_step_ff   <= rlfg_pkg::HUE_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            rlfg_pkg::REG_LED_COUNT:  led_count_ff  <= csr_wdata[6:0];
            rlfg_pkg::REG_SATURATION: saturation_ff <= csr_wdata[7:0];
            rlfg_pkg::REG_BRIGHTNESS: brightness_ff <= csr_wdata[7:0];
            rlfg_pkg::REG_HUE_STEP:   hue_step_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // base hue, the only state carried between frames
   logic [8:0] base_hue_ff;
   logic [8:0] step_mod;
   logic [9:0] base_sum;
   logic [8:0] base_hue_in;

   always_comb begin
      step_mod    = (hue_step_ff >= CIRCLE9) ? 9'(hue_step_ff - CIRCLE9) : hue_step_ff;
      base_sum    = {1'b0, base_hue_ff} + {1'b0, step_mod};
      base_hue_in = (base_sum >= CIRCLE10) ? 9'(base_sum - CIRCLE10) : base_sum[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_hue_ff <= '0;
      end else if (cmd.frame_done) begin
         base_hue_ff <= base_hue_in;
      end
   end

   // led count clamped to 1..LED_CAPACITY
   logic [CNT_W-1:0] count_clamp;

   always_comb begin
      if (led_count_ff == 7'd0) begin
         count_clamp = CNT_W'(1);
      end else if (led_count_ff > 7'(LED_CAPACITY)) begin
         count_clamp = CNT_W'(LED_CAPACITY);
      end else begin
         count_clamp = CNT_W'(led_count_ff);
      end
   end

   // restoring divider for 360 / count, one quotient bit a cycle
   logic [CNT_W-1:0] count_ff;
   logic [8:0]       div_num_ff;
   logic [8:0]       div_q_ff;
   logic [CNT_W-1:0] div_rem_ff;
   logic [3:0]       div_cnt_ff;
   logic [CNT_W:0]   div_trial;
   logic             div_ge;
   logic [CNT_W-1:0] div_rem_in;

   always_comb begin
      div_trial  = {div_rem_ff, div_num_ff[8]};
      div_ge     = div_trial >= {1'b0, count_ff};
      div_rem_in = div_ge ? CNT_W'(div_trial - {1'b0, count_ff}) : div_trial[CNT_W-1:0];
   end

   // min level: brightness * (255 - saturation) / 255
   logic [7:0]  top_ff;
   logic [15:0] bot_prod_ff;
   logic [7:0]  bot_ff;
   logic [16:0] bot_calc;

   // x / 255 for 16-bit x as (x + (x >> 8) + 1) >> 8
   assign bot_calc = 17'(bot_prod_ff) + 17'(bot_prod_ff >> 8) + 17'd1;

   // hue accumulator: offset of led i is i * 360 / count, tracked as quotient and remainder
   logic [CNT_W-1:0] idx_ff;
   logic [8:0]       offs_ff;
   logic [CNT_W-1:0] acc_rem_ff;
   logic [CNT_W:0]   rem_sum;
   logic             rem_wrap;

   always_comb begin
      rem_sum  = {1'b0, acc_rem_ff} + {1'b0, div_rem_ff};
      rem_wrap = rem_sum >= {1'b0, count_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff    <= count_clamp;
         div_num_ff  <= CIRCLE9;
         div_q_ff    <= '0;
         div_rem_ff  <= '0;
         div_cnt_ff  <= '0;
         top_ff      <= brightness_ff;
         bot_prod_ff <= 16'(brightness_ff * (8'(rlfg_pkg::LEVEL_MAX) - saturation_ff));
         idx_ff      <= '0;
         offs_ff     <= '0;
         acc_rem_ff  <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[7:0], 1'b0};
         div_q_ff   <= {div_q_ff[7:0], div_ge};
         div_rem_ff <= div_rem_in;
         div_cnt_ff <= div_cnt_ff + 4'd1;
         bot_ff     <= bot_calc[15:8];
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + CNT_W'(1);
         if (rem_wrap) begin
            acc_rem_ff <= CNT_W'(rem_sum - {1'b0, count_ff});
            offs_ff    <= offs_ff + div_q_ff + 9'd1;
         end else begin
            acc_rem_ff <= rem_sum[CNT_W-1:0];
            offs_ff    <= offs_ff + div_q_ff;
         end
      end
   end

   // per-led conversion pipeline, stepped one stage a cycle, held while a result waits to be taken
   logic [8:0]  hue_ff;
   logic [7:0]  span_ff;
   logic [2:0]  sector_ff;
   logic [13:0] prod_ff;
   logic [24:0] recip_ff;
   logic [9:0]  hue_sum;
   logic [8:0]  hue_in;
   logic [2:0]  sector_in;
   logic [8:0]  sector_start;
   logic [5:0]  hue_mod;
   logic [11:0] prod_q4;
   logic [8:0]  q_est;
   logic [11:0] q_rem;
   logic [7:0]  ramp;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;

   always_comb begin
      hue_sum = {1'b0, base_hue_ff} + {1'b0, offs_ff};
      hue_in  = (hue_sum >= CIRCLE10) ? 9'(hue_sum - CIRCLE10) : hue_sum[8:0];
   end

   always_comb begin
      if (hue_ff < 9'(rlfg_pkg::SECTOR_SPAN)) begin
         sector_in = 3'd0;
      end else if (hue_ff < 9'(rlfg_pkg::SECTOR_SPAN * 2)) begin
         sector_in = 3'd1;
      end else if (hue_ff < 9'(rlfg_pkg::SECTOR_SPAN * 3)) begin
         sector_in = 3'd2;
      end else if (hue_ff < 9'(rlfg_pkg::SECTOR_SPAN * 4)) begin
         sector_in = 3'd3;
      end else if (hue_ff < 9'(rlfg_pkg::SECTOR_SPAN * 5)) begin
         sector_in = 3'd4;
      end else begin
         sector_in = 3'd5;
      end
      sector_start = 9'(sector_in * 6'(rlfg_pkg::SECTOR_SPAN));
      hue_mod      = 6'(hue_ff - sector_start);
   end

   // x / 60 = (x / 4) / 15, quotient estimate is exact or one low
   always_comb begin
      prod_q4 = prod_ff[13:2];
      q_est   = recip_ff[24:16];
      q_rem   = prod_q4 - 12'(q_est * 4'd15);
      ramp    = (q_rem >= 12'd15) ? 8'(q_est + 9'd1) : 8'(q_est);
   end

   always_comb begin
      unique case (sector_ff)
         3'd0: begin
            red_in = top_ff;          green_in = bot_ff + ramp; blue_in = bot_ff;
         end
         3'd1: begin
            red_in = top_ff - ramp;   green_in = top_ff;        blue_in = bot_ff;
         end
         3'd2: begin
            red_in = bot_ff;          green_in = top_ff;        blue_in = bot_ff + ramp;
         end
         3'd3: begin
            red_in = bot_ff;          green_in = top_ff - ramp; blue_in = top_ff;
         end
         3'd4: begin
            red_in = bot_ff + ramp;   green_in = bot_ff;        blue_in = top_ff;
         end
         default: begin
            red_in = top_ff;          green_in = bot_ff;        blue_in = top_ff - ramp;
         end
      endcase
   end

   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;
   logic       last_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc_hue) begin
         hue_ff  <= hue_in;
         span_ff <= top_ff - bot_ff;
      end
      if (cmd.calc_mul) begin
         sector_ff <= sector_in;
         prod_ff   <= 14'(span_ff * hue_mod);
      end
      if (cmd.calc_rec) begin
         recip_ff <= 25'(prod_ff[13:2] * 13'(RECIP15));
      end
      if (cmd.calc_out) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         last_ff  <= idx_ff == CNT_W'(count_ff - CNT_W'(1));
      end
   end

   assign sts.div_done = div_cnt_ff == 4'd8;
   assign sts.last     = last_ff;

   assign led_index  = 6'(idx_ff);
   assign red        = red_ff;
   assign green      = green_ff;
   assign blue       = blue_ff;
   assign frame_last = last_ff;

`ifndef NO_ASSERTIONS
   // the divider has settled on 360 = q * count + r before any hue is formed
   a_div_result: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_hue |-> ((32'(div_q_ff) * 32'(count_ff) + 32'(div_rem_ff))
                        == 32'(rlfg_pkg::FULL_CIRCLE)) && (div_rem_ff < count_ff))
      else $error("hue spacing divider result inconsistent");

   // every led handled lies inside the frame and its offset stays below a full circle
   a_led_range: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_hue |-> (idx_ff < count_ff) && (offs_ff < CIRCLE9))
      else $error("led index or hue offset out of range");

   // no channel may exceed the max level after conversion
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_out |=> (red_ff <= top_ff) && (green_ff <= top_ff) && (blue_ff <= top_ff))
      else $error("channel level above brightness");

   // base hue stays on the circle
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      base_hue_ff < CIRCLE9)
      else $error("base hue out of range");
`endif

endmodule
